/* hdl/jagged_row_store_insert_delete_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the jagged row store
// Shared property forms; each use expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef JAGGED_ROW_STORE_INSERT_DELETE_MACROS_SVH
`define JAGGED_ROW_STORE_INSERT_DELETE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define JRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jrs assertion failed");

// Next-cycle implication, disabled in reset.
`define JRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jrs assertion failed");

`endif

/* hdl/jrs_pkg.sv */
// ----------------------------------------------------------------------------
// jrs_pkg
// Sizes, codes and controller/datapath command types of the jagged row store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jrs_pkg;

  localparam int ROWS = 64;
  localparam int COLS = 64;

  // fixed field widths
  localparam int KIND_W = 2;
  localparam int ROW_W  = 7;
  localparam int COL_W  = 6;
  localparam int CHAR_W = 8;
  localparam int STAT_W = 2;
  localparam int OLEN_W = 7;

  // derived sizes; one spare physical slot holds the row being built
  localparam int SLOTS      = ROWS + 1;
  localparam int CNT_W      = $clog2(ROWS + 1);
  localparam int IDX_W      = $clog2(ROWS);
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int PLEN_W     = $clog2(COLS + 1);
  localparam int CELL_DEPTH = SLOTS * COLS;
  localparam int CELL_AW    = $clog2(CELL_DEPTH);
  localparam int CMP_W      = (CNT_W > ROW_W) ? CNT_W : ROW_W;
  localparam int CCMP_W     = (PLEN_W > COL_W) ? PLEN_W : COL_W;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_PENDING = 2'd1;
  localparam logic [STAT_W-1:0] ST_REJECT  = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR   = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  // row map read selection
  typedef enum logic [2:0] {
    MR_NONE  = 3'd0,
    MR_COUNT = 3'd1,
    MR_ROW   = 3'd2,
    MR_UP    = 3'd3,
    MR_DOWN  = 3'd4
  } map_rsel_t;

  typedef enum logic [2:0] {
    RES_NONE    = 3'd0,
    RES_PENDING = 3'd1,
    RES_DONE    = 3'd2,
    RES_REJECT  = 3'd3,
    RES_READ    = 3'd4
  } res_sel_t;

  typedef struct packed {
    logic      latch;
    logic      append;
    logic      pend_reset;
    logic      len_wr;
    map_rsel_t map_rsel;
    logic      free_cap;
    logic      save_cap;
    logic      ins_put;
    logic      del_put;
    logic      clear;
    logic      data_rd;
    res_sel_t  res_sel;
    logic      load_out;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  last;
    logic  ins_ok;
    logic  row_ok;
    logic  up_more;
    logic  down_more;
    logic  out_free;
  } sts_t;

endpackage

/* hdl/jrs_in_if.sv */
// ----------------------------------------------------------------------------
// jrs_in_if
// Input channel of the jagged row store: valid/ready plus one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface jrs_in_if;
  logic                        valid;
  logic                        ready;
  logic [jrs_pkg::KIND_W-1:0]  kind;
  logic [jrs_pkg::ROW_W-1:0]   row;
  logic [jrs_pkg::COL_W-1:0]   column;
  logic [jrs_pkg::CHAR_W-1:0]  char_value;
  logic                        char_valid;
  logic                        last;

  modport source (output valid, kind, row, column, char_value, char_valid, last,
                  input ready);
  modport sink (input valid, kind, row, column, char_value, char_valid, last,
                output ready);
endinterface

/* hdl/jrs_out_if.sv */
// ----------------------------------------------------------------------------
// jrs_out_if
// Result channel of the jagged row store: valid/ready plus one result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface jrs_out_if;
  logic                        valid;
  logic                        ready;
  logic [jrs_pkg::STAT_W-1:0]  status;
  logic [jrs_pkg::CHAR_W-1:0]  read_char;
  logic [jrs_pkg::OLEN_W-1:0]  row_count;
  logic [jrs_pkg::OLEN_W-1:0]  row_length;

  modport source (output valid, status, read_char, row_count, row_length,
                  input ready);
  modport sink (input valid, status, read_char, row_count, row_length,
                output ready);
endinterface

/* hdl/jrs_ctrl.sv */
// ----------------------------------------------------------------------------
// jrs_ctrl
// Sequencer of the jagged row store: decodes an item, steps row map moves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jrs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  jrs_pkg::sts_t  sts,
  output jrs_pkg::cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_DECODE    = 11'b000_0000_0010,
    S_INS_FREE  = 11'b000_0000_0100,
    S_INS_SHIFT = 11'b000_0000_1000,
    S_INS_PUT   = 11'b000_0001_0000,
    S_DEL_SAVE  = 11'b000_0010_0000,
    S_DEL_SHIFT = 11'b000_0100_0000,
    S_DEL_PUT   = 11'b000_1000_0000,
    S_RD_MAP    = 11'b001_0000_0000,
    S_RD_DATA   = 11'b010_0000_0000,
    S_OUT       = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign item_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.kind)
          jrs_pkg::KIND_CHAR: begin
            cmd.append = 1'b1;
            if (!sts.last) begin
              cmd.res_sel = jrs_pkg::RES_PENDING;
              state_next  = S_OUT;
            end else if (sts.ins_ok) begin
              cmd.pend_reset = 1'b1;
              cmd.len_wr     = 1'b1;
              cmd.map_rsel   = jrs_pkg::MR_COUNT;
              state_next     = S_INS_FREE;
            end else begin
              cmd.pend_reset = 1'b1;
              cmd.res_sel    = jrs_pkg::RES_REJECT;
              state_next     = S_OUT;
            end
          end
          jrs_pkg::KIND_DELETE: begin
            if (sts.row_ok) begin
              cmd.map_rsel = jrs_pkg::MR_ROW;
              state_next   = S_DEL_SAVE;
            end else begin
              cmd.res_sel = jrs_pkg::RES_REJECT;
              state_next  = S_OUT;
            end
          end
          jrs_pkg::KIND_READ: begin
            if (sts.row_ok) begin
              cmd.map_rsel = jrs_pkg::MR_ROW;
              state_next   = S_RD_MAP;
            end else begin
              cmd.res_sel = jrs_pkg::RES_REJECT;
              state_next  = S_OUT;
            end
          end
          jrs_pkg::KIND_CLEAR: begin
            cmd.clear   = 1'b1;
            cmd.res_sel = jrs_pkg::RES_DONE;
            state_next  = S_OUT;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_INS_FREE: begin
        cmd.free_cap = 1'b1;
        state_next   = S_INS_SHIFT;
      end
      S_INS_SHIFT: begin
        // one map entry moves up per cycle
        if (sts.up_more) begin
          cmd.map_rsel = jrs_pkg::MR_UP;
        end else begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        cmd.ins_put = 1'b1;
        cmd.res_sel = jrs_pkg::RES_DONE;
        state_next  = S_OUT;
      end
      S_DEL_SAVE: begin
        cmd.save_cap = 1'b1;
        state_next   = S_DEL_SHIFT;
      end
      S_DEL_SHIFT: begin
        if (sts.down_more) begin
          cmd.map_rsel = jrs_pkg::MR_DOWN;
        end else begin
          state_next = S_DEL_PUT;
        end
      end
      S_DEL_PUT: begin
        cmd.del_put = 1'b1;
        cmd.res_sel = jrs_pkg::RES_DONE;
        state_next  = S_OUT;
      end
      S_RD_MAP: begin
        cmd.data_rd = 1'b1;
        state_next  = S_RD_DATA;
      end
      S_RD_DATA: begin
        cmd.res_sel = jrs_pkg::RES_READ;
        state_next  = S_OUT;
      end
      S_OUT: begin
        // hold the result until the output register frees up
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/jrs_dp.sv */
// ----------------------------------------------------------------------------
// jrs_dp
// Datapath of the jagged row store: cell, length and row map memories,
// counters, item latch and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "jagged_row_store_insert_delete_macros.svh"

module jrs_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  jrs_pkg::cmd_t               cmd,
  output jrs_pkg::sts_t               sts,
  input  logic [jrs_pkg::KIND_W-1:0]  kind,
  input  logic [jrs_pkg::ROW_W-1:0]   row,
  input  logic [jrs_pkg::COL_W-1:0]   column,
  input  logic [jrs_pkg::CHAR_W-1:0]  char_value,
  input  logic                        char_valid,
  input  logic                        last,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [jrs_pkg::STAT_W-1:0]  status,
  output logic [jrs_pkg::CHAR_W-1:0]  read_char,
  output logic [jrs_pkg::OLEN_W-1:0]  row_count,
  output logic [jrs_pkg::OLEN_W-1:0]  row_length
);

  localparam int ROWS    = jrs_pkg::ROWS;
  localparam int COLS    = jrs_pkg::COLS;
  localparam int CNT_W   = jrs_pkg::CNT_W;
  localparam int IDX_W   = jrs_pkg::IDX_W;
  localparam int SLOT_W  = jrs_pkg::SLOT_W;
  localparam int PLEN_W  = jrs_pkg::PLEN_W;
  localparam int CELL_AW = jrs_pkg::CELL_AW;
  localparam int CMP_W   = jrs_pkg::CMP_W;
  localparam int CCMP_W  = jrs_pkg::CCMP_W;
  localparam int CHAR_W  = jrs_pkg::CHAR_W;
  localparam int STAT_W  = jrs_pkg::STAT_W;
  localparam int OLEN_W  = jrs_pkg::OLEN_W;

  // memories
  logic [CHAR_W-1:0] cells [jrs_pkg::CELL_DEPTH];
  logic [PLEN_W-1:0] lens  [jrs_pkg::SLOTS];
  logic [SLOT_W-1:0] row_map [ROWS];

  // latched item
  logic [jrs_pkg::KIND_W-1:0] it_kind;
  logic [jrs_pkg::ROW_W-1:0]  it_row;
  logic [jrs_pkg::COL_W-1:0]  it_col;
  logic [CHAR_W-1:0]          it_char;
  logic                       it_cv;
  logic                       it_last;

  // table state; row_map[0..fill-1] and pend_slot together hold slots 0..fill
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  fill;
  logic [SLOT_W-1:0] pend_slot;
  logic [PLEN_W-1:0] plen;
  logic              ovf;

  // sequencing registers
  logic [IDX_W-1:0]  idx;
  logic [SLOT_W-1:0] free_slot;
  logic [SLOT_W-1:0] saved;
  logic              mv_valid;
  logic [IDX_W-1:0]  mv_dst;

  logic [SLOT_W-1:0] map_rdata;
  logic [PLEN_W-1:0] len_rdata;
  logic [CHAR_W-1:0] cell_rdata;

  logic [STAT_W-1:0] res_status;
  logic [CHAR_W-1:0] res_char;
  logic [OLEN_W-1:0] res_len;

  logic              plen_room;
  logic [PLEN_W-1:0] plen_next;
  logic              ovf_next;
  logic              map_re;
  logic [IDX_W-1:0]  map_raddr;
  logic              map_we;
  logic [IDX_W-1:0]  map_waddr;
  logic [SLOT_W-1:0] map_wdata;
  logic              out_free;
  logic              cell_we;
  logic [CELL_AW-1:0] cell_waddr;
  logic [CELL_AW-1:0] cell_raddr;
  logic              col_hit;

  assign plen_room = (plen < PLEN_W'(COLS));
  assign plen_next = plen + PLEN_W'(it_cv && plen_room);
  assign ovf_next  = ovf || (it_cv && !plen_room);
  assign out_free  = !out_valid || out_ready;
  assign cell_we   = cmd.append && it_cv && plen_room;
  assign cell_waddr = CELL_AW'(CELL_AW'(pend_slot) * CELL_AW'(COLS) + CELL_AW'(plen));
  assign cell_raddr = CELL_AW'(CELL_AW'(map_rdata) * CELL_AW'(COLS) + CELL_AW'(it_col));
  assign col_hit   = (CCMP_W'(it_col) < CCMP_W'(len_rdata));

  always_comb begin
    sts.kind      = jrs_pkg::kind_t'(it_kind);
    sts.last      = it_last;
    sts.ins_ok    = (count < CNT_W'(ROWS)) && !ovf_next
                    && (CMP_W'(it_row) <= CMP_W'(count));
    sts.row_ok    = (CMP_W'(it_row) < CMP_W'(count));
    sts.up_more   = (CMP_W'(idx) > CMP_W'(it_row));
    sts.down_more = ((CNT_W'(idx) + CNT_W'(1)) < count);
    sts.out_free  = out_free;
  end

  // row map read address
  always_comb begin
    map_re    = 1'b1;
    map_raddr = idx;
    case (cmd.map_rsel)
      jrs_pkg::MR_NONE:  map_re    = 1'b0;
      jrs_pkg::MR_COUNT: map_raddr = IDX_W'(count);
      jrs_pkg::MR_ROW:   map_raddr = IDX_W'(it_row);
      jrs_pkg::MR_UP:    map_raddr = idx - IDX_W'(1);
      jrs_pkg::MR_DOWN:  map_raddr = idx + IDX_W'(1);
      default:           map_re    = 1'b0;
    endcase
  end

  // one map write a cycle: a move in flight, or the final placement
  always_comb begin
    map_we    = 1'b0;
    map_waddr = mv_dst;
    map_wdata = map_rdata;
    if (mv_valid) begin
      map_we = 1'b1;
    end else if (cmd.ins_put) begin
      map_we    = 1'b1;
      map_waddr = IDX_W'(it_row);
      map_wdata = pend_slot;
    end else if (cmd.del_put) begin
      map_we    = 1'b1;
      map_waddr = IDX_W'(count - CNT_W'(1));
      map_wdata = saved;
    end
  end

  always_ff @(posedge clk) begin
    if (map_re) begin
      map_rdata <= row_map[map_raddr];
    end
    if (map_we) begin
      row_map[map_waddr] <= map_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.len_wr) begin
      lens[pend_slot] <= plen_next;
    end
    if (cmd.data_rd) begin
      len_rdata <= lens[map_rdata];
    end
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cells[cell_waddr] <= it_char;
    end
    if (cmd.data_rd) begin
      cell_rdata <= cells[cell_raddr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      it_kind <= kind;
      it_row  <= row;
      it_col  <= column;
      it_char <= char_value;
      it_cv   <= char_valid;
      it_last <= last;
    end
    case (cmd.map_rsel)
      jrs_pkg::MR_COUNT: idx <= IDX_W'(count);
      jrs_pkg::MR_ROW:   idx <= IDX_W'(it_row);
      jrs_pkg::MR_UP:    idx <= idx - IDX_W'(1);
      jrs_pkg::MR_DOWN:  idx <= idx + IDX_W'(1);
      default:           idx <= idx;
    endcase
    if (cmd.map_rsel == jrs_pkg::MR_UP || cmd.map_rsel == jrs_pkg::MR_DOWN) begin
      mv_dst <= idx;
    end
    if (cmd.free_cap) begin
      // a never-used slot when the whole map prefix is in use
      free_slot <= (count == fill) ? SLOT_W'(fill + CNT_W'(1)) : map_rdata;
    end
    if (cmd.save_cap) begin
      saved <= map_rdata;
    end
    case (cmd.res_sel)
      jrs_pkg::RES_PENDING: begin
        res_status <= jrs_pkg::ST_PENDING;
        res_char   <= '0;
        res_len    <= '0;
      end
      jrs_pkg::RES_DONE: begin
        res_status <= jrs_pkg::ST_DONE;
        res_char   <= '0;
        res_len    <= '0;
      end
      jrs_pkg::RES_REJECT: begin
        res_status <= jrs_pkg::ST_REJECT;
        res_char   <= '0;
        res_len    <= '0;
      end
      jrs_pkg::RES_READ: begin
        res_status <= col_hit ? jrs_pkg::ST_DONE : jrs_pkg::ST_REJECT;
        res_char   <= col_hit ? cell_rdata : '0;
        res_len    <= OLEN_W'(len_rdata);
      end
      default: begin
        res_status <= res_status;
      end
    endcase
    if (cmd.load_out) begin
      status     <= res_status;
      read_char  <= res_char;
      row_length <= res_len;
      row_count  <= OLEN_W'(count);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      fill      <= '0;
      pend_slot <= '0;
      plen      <= '0;
      ovf       <= 1'b0;
      mv_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mv_valid <= (cmd.map_rsel == jrs_pkg::MR_UP) || (cmd.map_rsel == jrs_pkg::MR_DOWN);
      if (cmd.append) begin
        plen <= plen_next;
        ovf  <= ovf_next;
      end
      if (cmd.pend_reset) begin
        plen <= '0;
        ovf  <= 1'b0;
      end
      if (cmd.ins_put) begin
        count     <= count + CNT_W'(1);
        pend_slot <= free_slot;
        if (count == fill) begin
          fill <= fill + CNT_W'(1);
        end
      end
      if (cmd.del_put) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.clear) begin
        count <= '0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `JRS_ASSERT_NOW(a_count_within_fill, 1'b1, (count <= fill) && (fill <= CNT_W'(ROWS)))
  `JRS_ASSERT_NOW(a_overflow_only_full, ovf, plen == PLEN_W'(COLS))
  `JRS_ASSERT_NOW(a_load_into_free_reg, cmd.load_out, !out_valid || out_ready)
  `JRS_ASSERT_NOW(a_single_map_write, mv_valid, !cmd.ins_put && !cmd.del_put)
  `JRS_ASSERT_NEXT(a_insert_grows, cmd.ins_put, count == $past(count) + CNT_W'(1))

endmodule

/* hdl/jagged_row_store_insert_delete.sv */
// ----------------------------------------------------------------------------
// jagged_row_store_insert_delete
// Ordered store of variable-length byte rows with insert, delete and read.
// ----------------------------------------------------------------------------
// Usage:
//   item   (valid/ready) carries one command beat: kind selects append a
//          character (last commits the built row as an insert at row),
//          delete row, read cell (row, column) or clear table.
//   result (valid/ready) returns exactly one beat per item: status,
//          read_char, row_count after the item, and row_length for reads.
// Throughput: one item at a time; the next beat is taken once the current
//   result sits in the output register. Insert and delete cost is set by the
//   row map shift, one map entry per cycle through its one read and one
//   write port.
// Rows are never copied: a row map points at physical slots, and one spare
//   slot takes the bytes of the row being built.
// Reset clears the row count, the pending row and the output valid; the
//   memories need no clearing pass and are ready in the first cycle.
// A stalled result holds in the output register; the next item is still
//   accepted and processed, and waits only to load its own result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jagged_row_store_insert_delete (
  input  logic       clk,
  input  logic       rst,
  jrs_in_if.sink     item,
  jrs_out_if.source  result
);

  // command and status between sequencer and datapath
  jrs_pkg::cmd_t cmd;
  jrs_pkg::sts_t sts;

  // sequencer: accepts a beat only when idle, steps the map shift
  jrs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // datapath: memories, counters and the output register
  jrs_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .kind       (item.kind),
    .row        (item.row),
    .column     (item.column),
    .char_value (item.char_value),
    .char_valid (item.char_valid),
    .last       (item.last),
    .out_ready  (result.ready),
    .out_valid  (result.valid),
    .status     (result.status),
    .read_char  (result.read_char),
    .row_count  (result.row_count),
    .row_length (result.row_length)
  );

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the jagged row store. A queue of command beats
// (directed opening, then random fill and drain passes over the table) feeds
// a negedge driver; a posedge monitor runs a shadow of the row store on every
// accepted beat and checks each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int ROWS   = jrs_pkg::ROWS;
  localparam int COLS   = jrs_pkg::COLS;
  localparam int ROW_W  = jrs_pkg::ROW_W;
  localparam int COL_W  = jrs_pkg::COL_W;
  localparam int CHAR_W = jrs_pkg::CHAR_W;
  localparam int STAT_W = jrs_pkg::STAT_W;
  localparam int OLEN_W = jrs_pkg::OLEN_W;

  localparam int ITEMS_RANDOM = 450;
  localparam int LIMIT_CYCLES = 400000;
  localparam int TAIL_CYCLES  = 100;    // longest insert or delete plus slack

  // one command beat as queued for the driver; wait_idle holds it back
  // until every earlier result has come out
  typedef struct {
    jrs_pkg::kind_t      kind;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    column;
    logic [CHAR_W-1:0]   char_value;
    logic                char_valid;
    logic                last;
    bit                  wait_idle;
  } command_t;

  typedef struct {
    logic [STAT_W-1:0]   status;
    logic [CHAR_W-1:0]   read_char;
    logic [OLEN_W-1:0]   row_count;
    logic [OLEN_W-1:0]   row_length;
  } outcome_t;

  logic clk;
  logic rst;

  jrs_in_if  in_if ();
  jrs_out_if out_if ();

  jagged_row_store_insert_delete dut (
    .clk    (clk),
    .rst    (rst),
    .item   (in_if),
    .result (out_if)
  );

  // --------------------------------------------------------------------------
  // Shadow row store: table of rows, row lengths, row count and the row
  // under construction. Bytes past a row's length are never read.
  // --------------------------------------------------------------------------
  logic [CHAR_W-1:0] sh_cells [ROWS][COLS];
  int                sh_len [ROWS];
  int                sh_count = 0;
  logic [CHAR_W-1:0] sh_pend [COLS];
  int                sh_plen = 0;
  bit                sh_povf = 1'b0;

  command_t command_q [$];     // beats not yet handed to the driver
  outcome_t outcome_q [$];     // predicted results not yet seen
  int       n_total = 0;       // beats queued
  int       n_accepted = 0;    // beats taken by the block
  int       errors = 0;
  int       cycles = 0;
  bit       beat_taken = 1'b0;

  // count tracker used only to steer the generator toward valid positions
  int       gen_count = 0;
  int       gen_plen = 0;
  bit       gen_ovf = 1'b0;
  bit       wait_next = 1'b0;

  // no idling on either side for a stretch in the middle of the run
  wire calm = (n_accepted >= 200) && (n_accepted < 300);

  // Apply one accepted beat to the shadow store and return its result.
  function automatic outcome_t store_apply(command_t s);
    outcome_t o;
    int       r;
    int       c;
    o.status     = jrs_pkg::ST_DONE;
    o.read_char  = '0;
    o.row_length = '0;
    case (s.kind)
      jrs_pkg::KIND_CHAR: begin
        // a byte past a full pending row is dropped and poisons the commit
        if (s.char_valid) begin
          if (sh_plen < COLS) begin
            sh_pend[sh_plen] = s.char_value;
            sh_plen++;
          end else begin
            sh_povf = 1'b1;
          end
        end
        if (!s.last) begin
          o.status = jrs_pkg::ST_PENDING;
        end else begin
          if (sh_count >= ROWS || sh_povf || s.row > sh_count) begin
            o.status = jrs_pkg::ST_REJECT;
          end else begin
            // open a gap at the insert position
            for (r = sh_count; r > s.row; r--) begin
              for (c = 0; c < COLS; c++) sh_cells[r][c] = sh_cells[r-1][c];
              sh_len[r] = sh_len[r-1];
            end
            for (c = 0; c < sh_plen; c++) sh_cells[s.row][c] = sh_pend[c];
            sh_len[s.row] = sh_plen;
            sh_count++;
          end
          // the pending row empties whether or not the insert took
          sh_plen = 0;
          sh_povf = 1'b0;
        end
      end
      jrs_pkg::KIND_DELETE: begin
        if (s.row >= sh_count) begin
          o.status = jrs_pkg::ST_REJECT;
        end else begin
          for (r = s.row; r + 1 < sh_count; r++) begin
            for (c = 0; c < COLS; c++) sh_cells[r][c] = sh_cells[r+1][c];
            sh_len[r] = sh_len[r+1];
          end
          sh_count--;
        end
      end
      jrs_pkg::KIND_READ: begin
        if (s.row >= sh_count) begin
          o.status = jrs_pkg::ST_REJECT;
        end else if (s.column >= sh_len[s.row]) begin
          o.status     = jrs_pkg::ST_REJECT;
          o.row_length = OLEN_W'(sh_len[s.row]);
        end else begin
          o.read_char  = sh_cells[s.row][s.column];
          o.row_length = OLEN_W'(sh_len[s.row]);
        end
      end
      default: begin
        // clear drops the rows but keeps the pending row
        sh_count = 0;
      end
    endcase
    o.row_count = OLEN_W'(sh_count);
    return o;
  endfunction

  // Queue one beat and keep the generator's row count in step.
  task automatic add_beat(jrs_pkg::kind_t k, int r, int c, int ch, bit cv, bit lst);
    command_t e;
    e.kind       = k;
    e.row        = ROW_W'(r);
    e.column     = COL_W'(c);
    e.char_value = CHAR_W'(ch);
    e.char_valid = cv;
    e.last       = lst;
    e.wait_idle  = wait_next;
    wait_next    = 1'b0;
    command_q.push_back(e);
    n_total++;
    case (k)
      jrs_pkg::KIND_CHAR: begin
        if (cv) begin
          if (gen_plen < COLS) gen_plen++;
          else gen_ovf = 1'b1;
        end
        if (lst) begin
          if (gen_count < ROWS && !gen_ovf && r <= gen_count) gen_count++;
          gen_plen = 0;
          gen_ovf  = 1'b0;
        end
      end
      jrs_pkg::KIND_DELETE: if (r < gen_count) gen_count--;
      jrs_pkg::KIND_CLEAR:  gen_count = 0;
      default: ;
    endcase
  endtask

  // Pick a row index: mostly inside 0..span-1, with both ends and some
  // positions out of range.
  function automatic int pick_row(int span);
    if (span == 0) return $urandom_range(2);
    case ($urandom_range(9))
      0:       return $urandom_range(127);
      1:       return 0;
      2:       return span - 1;
      default: return $urandom_range(span - 1);
    endcase
  endfunction

  function automatic int pick_column();
    if ($urandom_range(7) == 0) return $urandom_range(63);
    return $urandom_range(3);
  endfunction

  // Build a row of n bytes and commit it at pos. The last byte rides on the
  // commit beat half the time; now and then a no-append beat or a read
  // lands in the middle of the build.
  task automatic add_row(int n, int pos);
    bit tail_char;
    int i;
    tail_char = (n > 0) && ($urandom_range(1) == 1);
    for (i = 0; i < n - int'(tail_char); i++) begin
      if ($urandom_range(19) == 0)
        add_beat(jrs_pkg::KIND_CHAR, $urandom_range(127), $urandom_range(63),
                 $urandom_range(255), 1'b0, 1'b0);
      if ($urandom_range(39) == 0)
        add_beat(jrs_pkg::KIND_READ, pick_row(gen_count), pick_column(),
                 $urandom_range(255), 1'($urandom_range(1)), 1'($urandom_range(1)));
      add_beat(jrs_pkg::KIND_CHAR, $urandom_range(127), $urandom_range(63),
               $urandom_range(255), 1'b1, 1'b0);
    end
    add_beat(jrs_pkg::KIND_CHAR, pos, $urandom_range(63), $urandom_range(255),
             tail_char, 1'b1);
  endtask

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: change inputs on the falling edge. Advance to the next beat only
  // once the current one was taken; idle at random outside the calm stretch,
  // and hold a marked beat until all earlier results are back.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    command_t e;
    if (rst) begin
      in_if.valid      <= 1'b0;
      in_if.kind       <= jrs_pkg::KIND_CHAR;
      in_if.row        <= '0;
      in_if.column     <= '0;
      in_if.char_value <= '0;
      in_if.char_valid <= 1'b0;
      in_if.last       <= 1'b0;
      out_if.ready     <= 1'b0;
    end else begin
      if (!in_if.valid || beat_taken) begin
        if (command_q.size() != 0 && (calm || $urandom_range(99) >= 7) &&
            !(command_q[0].wait_idle && outcome_q.size() != 0)) begin
          e = command_q.pop_front();
          in_if.kind       <= e.kind;
          in_if.row        <= e.row;
          in_if.column     <= e.column;
          in_if.char_value <= e.char_value;
          in_if.char_valid <= e.char_valid;
          in_if.last       <= e.last;
          in_if.valid      <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: on the rising edge, predict every accepted command beat, then
  // check every accepted result beat against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    command_t s;
    outcome_t w;
    if (rst) begin
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        s.kind       = jrs_pkg::kind_t'(in_if.kind);
        s.row        = in_if.row;
        s.column     = in_if.column;
        s.char_value = in_if.char_value;
        s.char_valid = in_if.char_valid;
        s.last       = in_if.last;
        s.wait_idle  = 1'b0;
        outcome_q.push_back(store_apply(s));
        n_accepted++;
      end
      if (out_if.valid && out_if.ready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result beat with none expected: status %0d count %0d",
                   $time, out_if.status, out_if.row_count);
          errors++;
        end else begin
          w = outcome_q.pop_front();
          check_field("status", int'(w.status), int'(out_if.status));
          check_field("read_char", int'(w.read_char), int'(out_if.read_char));
          check_field("row_count", int'(w.row_count), int'(out_if.row_count));
          check_field("row_length", int'(w.row_length), int'(out_if.row_length));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int  seq;
    int  pick;
    int  stop_at;
    int  full_hits;
    bit  filling;

    rst = 1'b1;

    // directed opening: empty table, both byte extremes, insert past the
    // end, delete of the row at index count, clear with a row pending
    add_beat(jrs_pkg::KIND_READ,   0,   0,  0,    1'b0, 1'b0);  // read on empty table
    add_beat(jrs_pkg::KIND_DELETE, 0,   63, 255,  1'b1, 1'b1);  // delete on empty table
    add_beat(jrs_pkg::KIND_CLEAR,  127, 0,  0,    1'b0, 1'b0);
    add_beat(jrs_pkg::KIND_CHAR,   0,   0,  0,    1'b0, 1'b1);  // commit an empty row
    add_beat(jrs_pkg::KIND_READ,   0,   0,  0,    1'b0, 1'b0);  // column past zero length
    add_beat(jrs_pkg::KIND_CHAR,   127, 63, 8'h00, 1'b1, 1'b0);
    add_beat(jrs_pkg::KIND_CHAR,   1,   0,  8'hFF, 1'b1, 1'b1); // byte rides on commit
    add_beat(jrs_pkg::KIND_CHAR,   64,  0,  8'h5A, 1'b1, 1'b1); // insert past the end
    add_beat(jrs_pkg::KIND_READ,   1,   0,  0,    1'b0, 1'b0);
    add_beat(jrs_pkg::KIND_READ,   1,   1,  0,    1'b0, 1'b0);
    add_beat(jrs_pkg::KIND_READ,   1,   63, 0,    1'b0, 1'b0);
    add_beat(jrs_pkg::KIND_CHAR,   0,   0,  8'hA5, 1'b0, 1'b0); // appends nothing
    add_beat(jrs_pkg::KIND_CHAR,   0,   0,  8'h3C, 1'b1, 1'b0);
    add_beat(jrs_pkg::KIND_READ,   1,   1,  0,    1'b0, 1'b0);  // read with a row pending
    add_beat(jrs_pkg::KIND_DELETE, 2,   0,  0,    1'b0, 1'b0);  // row index equal to count
    add_beat(jrs_pkg::KIND_CHAR,   0,   0,  0,    1'b0, 1'b1);  // commit at the front
    add_beat(jrs_pkg::KIND_READ,   0,   0,  0,    1'b0, 1'b0);
    add_beat(jrs_pkg::KIND_DELETE, 2,   0,  0,    1'b0, 1'b0);  // delete the last row
    add_beat(jrs_pkg::KIND_DELETE, 0,   0,  0,    1'b0, 1'b0);  // delete the first row
    add_beat(jrs_pkg::KIND_CHAR,   0,   0,  8'h7E, 1'b1, 1'b0);
    add_beat(jrs_pkg::KIND_CLEAR,  0,   0,  0,    1'b0, 1'b0);  // pending row survives
    add_beat(jrs_pkg::KIND_CHAR,   0,   0,  8'h81, 1'b1, 1'b1);
    add_beat(jrs_pkg::KIND_READ,   0,   1,  0,    1'b0, 1'b0);
    add_beat(jrs_pkg::KIND_READ,   127, 63, 0,    1'b0, 1'b0);
    add_beat(jrs_pkg::KIND_DELETE, 127, 0,  0,    1'b0, 1'b0);

    // random part: fill the table until it rejects for being full a few
    // times, then drain it back to empty, and repeat
    stop_at   = n_total + ITEMS_RANDOM;
    filling   = 1'b1;
    full_hits = 0;
    wait_next = 1'b1;
    for (seq = 0; n_total < stop_at; seq++) begin
      pick = $urandom_range(99);
      if (seq == 8) begin
        add_row(COLS, pick_row(gen_count + 1));                 // full-width row
      end else if (seq == 40) begin
        add_row(COLS + 1 + $urandom_range(1), pick_row(gen_count + 1)); // overflow
      end else if (pick < (filling ? 70 : 15)) begin
        if (gen_count == ROWS) full_hits++;
        add_row($urandom_range(3), pick_row(gen_count + 1));
      end else if (pick < (filling ? 78 : 70)) begin
        add_beat(jrs_pkg::KIND_DELETE, pick_row(gen_count), $urandom_range(63),
                 $urandom_range(255), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (pick < (filling ? 100 : 98)) begin
        add_beat(jrs_pkg::KIND_READ, pick_row(gen_count), pick_column(),
                 $urandom_range(255), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        add_beat(jrs_pkg::KIND_CLEAR, $urandom_range(127), $urandom_range(63),
                 $urandom_range(255), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      // hold the sender at each change of direction until the block drains
      if (filling && full_hits >= 3) begin
        filling   = 1'b0;
        wait_next = 1'b1;
      end else if (!filling && gen_count == 0) begin
        filling   = 1'b1;
        full_hits = 0;
        wait_next = 1'b1;
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (n_accepted < n_total) @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/jrs_pkg.sv
hdl/jrs_in_if.sv
hdl/jrs_out_if.sv
hdl/jrs_ctrl.sv
hdl/jrs_dp.sv
hdl/jagged_row_store_insert_delete.sv
tb/sv/testbench.sv
